>>> rtl/core/dpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_pkg: shared definitions for the demand paging translator
// Widths, reset values and status codes used by the front, queue and back.
// ----------------------------------------------------------------------------
package dpt_pkg;

	localparam int NUM_PAGES_DEF  = 1024;
	localparam int NUM_FRAMES_DEF = 1024;
	localparam int VADDR_BITS_DEF = 32;

	localparam int VA_IN_W  = 32;
	localparam int PS_W     = 17;
	localparam int OFF_W    = 16;
	localparam int PA_W     = 26;
	localparam int FRAME_OW = 10;
	localparam int CNT_W    = 32;
	localparam int ST_W     = 2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [PS_W-1:0] PAGE_SIZE_RESET = 17'd4096;
	localparam logic [PS_W-1:0] PAGE_SIZE_MIN   = 17'd1;
	localparam logic [PS_W-1:0] PAGE_SIZE_MAX   = 17'd65536;

	localparam logic [ST_W-1:0] ST_HIT    = 2'd0;
	localparam logic [ST_W-1:0] ST_LOADED = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

endpackage

>>> rtl/core/dpt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/dpt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_fifo: short request queue between front and back
// Two entries, so the divider can finish while the back is still working.
// ----------------------------------------------------------------------------
module dpt_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(dpt_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(dpt_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [dpt_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(dpt_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(dpt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(dpt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/dpt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_front: address split
// Bit-serial restoring divider that yields page number and offset, then a
// range check, and hands the classified request to the queue.
// ----------------------------------------------------------------------------
module dpt_front #(
	parameter int NUM_PAGES  = dpt_pkg::NUM_PAGES_DEF,
	parameter int VADDR_BITS = dpt_pkg::VADDR_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start_acc,
	input  logic [dpt_pkg::VA_IN_W-1:0]  virtual_address,
	input  logic [dpt_pkg::PS_W-1:0]     page_size,
	output logic                         busy,
	output logic                         push,
	output logic [1+$clog2(NUM_PAGES)+dpt_pkg::OFF_W+dpt_pkg::PS_W-1:0] entry,
	input  logic                         full
);

	localparam int VA_W   = (VADDR_BITS < dpt_pkg::VA_IN_W) ? VADDR_BITS : dpt_pkg::VA_IN_W;
	localparam int PAGE_W = $clog2(NUM_PAGES);
	localparam int STEP_W = $clog2(VA_W);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]                 state_q;
	logic [STEP_W-1:0]          step_q;
	logic [VA_W-1:0]            va_q;      // dividend shifts out, quotient shifts in
	logic [dpt_pkg::OFF_W-1:0]  rem_q;
	logic [dpt_pkg::PS_W-1:0]   ps_q;

	logic [dpt_pkg::PS_W-1:0]   trial;
	logic                       fits;
	logic [dpt_pkg::OFF_W-1:0]  rem_n;
	logic                       out_of_range;

	assign trial = {rem_q, va_q[VA_W-1]};
	assign fits  = (trial >= ps_q);
	assign rem_n = fits ? dpt_pkg::OFF_W'(trial - ps_q) : trial[dpt_pkg::OFF_W-1:0];

	assign out_of_range = (64'(va_q) >= 64'(NUM_PAGES));

	assign busy  = (state_q != F_IDLE);
	assign push  = (state_q == F_PUSH) && !full;
	assign entry = {out_of_range, PAGE_W'(va_q), rem_q, ps_q};

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (start_acc) begin
					va_q  <= virtual_address[VA_W-1:0];
					rem_q <= '0;
					ps_q  <= page_size;
				end
			end
			F_DIV: begin
				va_q  <= {va_q[VA_W-2:0], fits};
				rem_q <= rem_n;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (start_acc) begin
						state_q <= F_DIV;
						step_q  <= STEP_W'(VA_W - 1);
					end
				end
				F_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/dpt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_back: page table walk and result
// Clears the page table after reset, then per request looks up the page,
// allocates a frame on a fault, forms the physical address and counts.
// ----------------------------------------------------------------------------
module dpt_back #(
	parameter int NUM_PAGES  = dpt_pkg::NUM_PAGES_DEF,
	parameter int NUM_FRAMES = dpt_pkg::NUM_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  logic [1+$clog2(NUM_PAGES)+dpt_pkg::OFF_W+dpt_pkg::PS_W-1:0] entry,
	output logic                          pop,
	output logic                          clearing,
	output logic                          done,
	output logic [dpt_pkg::PA_W-1:0]      physical_address,
	output logic [dpt_pkg::FRAME_OW-1:0]  frame_number,
	output logic [dpt_pkg::ST_W-1:0]      status,
	output logic [dpt_pkg::CNT_W-1:0]     translation_count,
	output logic [dpt_pkg::CNT_W-1:0]     fault_count
);

	localparam int PAGE_W  = $clog2(NUM_PAGES);
	localparam int FRAME_W = $clog2(NUM_FRAMES);
	localparam int NFF_W   = $clog2(NUM_FRAMES + 1);
	localparam int PROD_W  = FRAME_W + dpt_pkg::PS_W;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_LOOK = 2'd1;
	localparam logic [1:0] B_OUT  = 2'd2;

	logic [1:0]                  state_q;
	logic                        clearing_q;
	logic [PAGE_W-1:0]           clr_q;
	logic [NFF_W-1:0]            nff_q;
	logic [dpt_pkg::CNT_W-1:0]   trans_q;
	logic [dpt_pkg::CNT_W-1:0]   faults_q;
	logic                        done_q;

	logic                        range_q;
	logic [PAGE_W-1:0]           vpn_q;
	logic [dpt_pkg::OFF_W-1:0]   off_q;
	logic [dpt_pkg::PS_W-1:0]    ps_q;
	logic [dpt_pkg::ST_W-1:0]    st_q;
	logic [FRAME_W-1:0]          fr_q;
	logic [PROD_W-1:0]           prod_q;
	logic [dpt_pkg::PA_W-1:0]    pa_q;

	logic                        head_range;
	logic [PAGE_W-1:0]           head_vpn;
	logic [dpt_pkg::OFF_W-1:0]   head_off;
	logic [dpt_pkg::PS_W-1:0]    head_ps;

	logic [FRAME_W:0]            rdata;
	logic                        ram_we;
	logic [PAGE_W-1:0]           ram_waddr;
	logic [FRAME_W:0]            ram_wdata;

	logic [dpt_pkg::ST_W-1:0]    st_n;
	logic [FRAME_W-1:0]          fr_n;
	logic                        fault_n;
	logic                        load_n;
	logic [PROD_W-1:0]           pa_sum;

	assign {head_range, head_vpn, head_off, head_ps} = entry;

	assign pop      = (state_q == B_IDLE) && !empty && !clearing_q;
	assign clearing = clearing_q;

	// Lookup decision on the entry read out of the table.
	always_comb begin
		st_n    = dpt_pkg::ST_HIT;
		fr_n    = '0;
		fault_n = 1'b0;
		load_n  = 1'b0;
		if (range_q) begin
			st_n = dpt_pkg::ST_RANGE;
		end else if (rdata[FRAME_W]) begin
			st_n = dpt_pkg::ST_HIT;
			fr_n = rdata[FRAME_W-1:0];
		end else begin
			fault_n = 1'b1;
			if (nff_q == NFF_W'(NUM_FRAMES)) begin
				st_n = dpt_pkg::ST_FULL;
			end else begin
				st_n   = dpt_pkg::ST_LOADED;
				fr_n   = nff_q[FRAME_W-1:0];
				load_n = 1'b1;
			end
		end
	end

	// The clearing pass owns the write port until every entry is invalid.
	assign ram_we    = clearing_q || ((state_q == B_LOOK) && load_n);
	assign ram_waddr = clearing_q ? clr_q : vpn_q;
	assign ram_wdata = clearing_q ? '0 : {1'b1, nff_q[FRAME_W-1:0]};

	dpt_ram #(
		.WIDTH (FRAME_W + 1),
		.DEPTH (NUM_PAGES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (pop),
		.raddr (head_vpn),
		.rdata (rdata)
	);

	assign pa_sum = prod_q + PROD_W'(off_q);

	always_ff @(posedge clk) begin
		if (pop) begin
			range_q <= head_range;
			vpn_q   <= head_vpn;
			off_q   <= head_off;
			ps_q    <= head_ps;
		end
		if (state_q == B_LOOK) begin
			st_q   <= st_n;
			fr_q   <= fr_n;
			prod_q <= PROD_W'(fr_n) * PROD_W'(ps_q);
		end
		if (state_q == B_OUT) begin
			if (st_q == dpt_pkg::ST_HIT || st_q == dpt_pkg::ST_LOADED) begin
				pa_q <= dpt_pkg::PA_W'(pa_sum);
			end else begin
				pa_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			clearing_q <= 1'b1;
			clr_q      <= '0;
			nff_q      <= '0;
			trans_q    <= '0;
			faults_q   <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= (state_q == B_OUT);
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == PAGE_W'(NUM_PAGES - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= B_LOOK;
					end
				end
				B_LOOK: begin
					trans_q <= trans_q + 1'b1;
					if (fault_n) begin
						faults_q <= faults_q + 1'b1;
					end
					if (load_n) begin
						nff_q <= nff_q + 1'b1;
					end
					state_q <= B_OUT;
				end
				B_OUT: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign done              = done_q;
	assign physical_address  = pa_q;
	assign frame_number      = dpt_pkg::FRAME_OW'(fr_q);
	assign status            = st_q;
	assign translation_count = trans_q;
	assign fault_count       = faults_q;

endmodule

>>> rtl/core/demand_paging_translator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_paging_translator: single-level demand paging address translator
// Splits a virtual address by the page size, walks a direct page table and
// allocates frames on faults from a bump counter.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The address split
// runs on a bit-serial divider, one quotient bit per cycle, so the front is
// busy while it divides and until the queue takes the request, and the next
// request can follow right after; behind a two-entry queue the back reads
// the table, then decides and multiplies, then adds the offset, each step
// registered. Each result appears for a single cycle with done high and
// cannot be held off. After reset the page table is cleared one entry per
// cycle, and busy stays high until every entry is clear, so no request is
// taken before then. page_size may be written at any time the block is idle;
// 0 is taken as 1 and values above 65536 as 65536.
// ----------------------------------------------------------------------------
module demand_paging_translator #(
	parameter int NUM_PAGES  = dpt_pkg::NUM_PAGES_DEF,
	parameter int NUM_FRAMES = dpt_pkg::NUM_FRAMES_DEF,
	parameter int VADDR_BITS = dpt_pkg::VADDR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [dpt_pkg::VA_IN_W-1:0]   virtual_address,
	input  logic                          page_size_we,
	input  logic [dpt_pkg::PS_W-1:0]      page_size,
	output logic                          done,
	output logic [dpt_pkg::PA_W-1:0]      physical_address,
	output logic [dpt_pkg::FRAME_OW-1:0]  frame_number,
	output logic [dpt_pkg::ST_W-1:0]      status,
	output logic [dpt_pkg::CNT_W-1:0]     translation_count,
	output logic [dpt_pkg::CNT_W-1:0]     fault_count
);

	localparam int ENT_W = 1 + $clog2(NUM_PAGES) + dpt_pkg::OFF_W + dpt_pkg::PS_W;

	logic [dpt_pkg::PS_W-1:0] page_size_q;
	logic                     start_acc;
	logic                     front_busy;
	logic                     clearing;
	logic                     q_push;
	logic                     q_pop;
	logic                     q_full;
	logic                     q_empty;
	logic [ENT_W-1:0]         q_wdata;
	logic [ENT_W-1:0]         q_rdata;

	assign busy      = clearing || front_busy;
	assign start_acc = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= dpt_pkg::PAGE_SIZE_RESET;
		end else if (page_size_we) begin
			if (page_size == '0) begin
				page_size_q <= dpt_pkg::PAGE_SIZE_MIN;
			end else if (page_size > dpt_pkg::PAGE_SIZE_MAX) begin
				page_size_q <= dpt_pkg::PAGE_SIZE_MAX;
			end else begin
				page_size_q <= page_size;
			end
		end
	end

	dpt_front #(
		.NUM_PAGES  (NUM_PAGES),
		.VADDR_BITS (VADDR_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start_acc       (start_acc),
		.virtual_address (virtual_address),
		.page_size       (page_size_q),
		.busy            (front_busy),
		.push            (q_push),
		.entry           (q_wdata),
		.full            (q_full)
	);

	dpt_fifo #(
		.WIDTH (ENT_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	dpt_back #(
		.NUM_PAGES  (NUM_PAGES),
		.NUM_FRAMES (NUM_FRAMES)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.empty             (q_empty),
		.entry             (q_rdata),
		.pop               (q_pop),
		.clearing          (clearing),
		.done              (done),
		.physical_address  (physical_address),
		.frame_number      (frame_number),
		.status            (status),
		.translation_count (translation_count),
		.fault_count       (fault_count)
	);

endmodule

>>> rtl/core/dpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpt_checker: port-level checks for the translator
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module dpt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [dpt_pkg::PA_W-1:0]      physical_address,
	input logic [dpt_pkg::FRAME_OW-1:0]  frame_number,
	input logic [dpt_pkg::ST_W-1:0]      status
);

	// A taken request keeps the divider occupied for the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after a request was taken");

	// The back passes through its lookup and output states for each request, so results never come back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe high in two consecutive cycles");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == dpt_pkg::ST_RANGE || status == dpt_pkg::ST_FULL))
		|-> (physical_address == '0 && frame_number == '0))
		else $error("error result carries a nonzero address or frame");

endmodule

bind demand_paging_translator dpt_checker u_dpt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.physical_address (physical_address),
	.frame_number     (frame_number),
	.status           (status)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for demand_paging_translator
// Sends directed and random address requests with random idle gaps,
// reprograms the page size between phases, predicts every translation with
// a behavioral page table and checks each result field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int NUM_PAGES      = dpt_pkg::NUM_PAGES_DEF;
	localparam int NUM_FRAMES     = dpt_pkg::NUM_FRAMES_DEF;
	localparam int PAGE_W         = $clog2(NUM_PAGES);
	localparam int RANDOM_ITEMS   = 830;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [dpt_pkg::PA_W-1:0]     paddr;
		logic [dpt_pkg::FRAME_OW-1:0] frame;
		logic [dpt_pkg::ST_W-1:0]     st;
		logic [dpt_pkg::CNT_W-1:0]    xlat_cnt;
		logic [dpt_pkg::CNT_W-1:0]    fault_cnt;
	} xlat_t;

	typedef struct {
		bit                          is_cfg;
		logic [dpt_pkg::PS_W-1:0]    size_val;
		logic [dpt_pkg::VA_IN_W-1:0] vaddr;
	} request_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic [dpt_pkg::VA_IN_W-1:0]   virtual_address = '0;
	logic                          page_size_we = 1'b0;
	logic [dpt_pkg::PS_W-1:0]      page_size = dpt_pkg::PAGE_SIZE_RESET;
	logic                          busy;
	logic                          done;
	logic [dpt_pkg::PA_W-1:0]      physical_address;
	logic [dpt_pkg::FRAME_OW-1:0]  frame_number;
	logic [dpt_pkg::ST_W-1:0]      status;
	logic [dpt_pkg::CNT_W-1:0]     translation_count;
	logic [dpt_pkg::CNT_W-1:0]     fault_count;

	demand_paging_translator DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.virtual_address   (virtual_address),
		.page_size_we      (page_size_we),
		.page_size         (page_size),
		.done              (done),
		.physical_address  (physical_address),
		.frame_number      (frame_number),
		.status            (status),
		.translation_count (translation_count),
		.fault_count       (fault_count)
	);

	// Shadow page table and counters.
	bit                           page_mapped [NUM_PAGES];
	logic [dpt_pkg::FRAME_OW-1:0] page_frame_of [NUM_PAGES];
	logic [10:0]                  next_frame = '0;
	logic [dpt_pkg::CNT_W-1:0]    xlat_total = '0;
	logic [dpt_pkg::CNT_W-1:0]    fault_total = '0;
	logic [dpt_pkg::PS_W-1:0]     cur_page_size = dpt_pkg::PAGE_SIZE_RESET;

	request_t pending[$];
	xlat_t    expected_xlat[$];
	int       mismatches = 0;
	int       idle_cycles = 0;
	bit       timed_out = 1'b0;
	int       gap_left = 0;
	bit       calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [dpt_pkg::PS_W-1:0] clamp_size(logic [dpt_pkg::PS_W-1:0] v);
		if (v == '0)
			return dpt_pkg::PAGE_SIZE_MIN;
		if (v > dpt_pkg::PAGE_SIZE_MAX)
			return dpt_pkg::PAGE_SIZE_MAX;
		return v;
	endfunction

	function automatic xlat_t translate_address(logic [dpt_pkg::VA_IN_W-1:0] va);
		xlat_t r;
		longint unsigned vpn, off, fr;
		logic [PAGE_W-1:0] idx;
		vpn = 64'(va) / 64'(cur_page_size);
		off = 64'(va) % 64'(cur_page_size);
		idx = PAGE_W'(vpn);
		r = '0;
		xlat_total = xlat_total + 32'd1;
		if (vpn >= NUM_PAGES) begin
			r.st = dpt_pkg::ST_RANGE;
		end else if (page_mapped[idx]) begin
			r.st = dpt_pkg::ST_HIT;
			r.frame = page_frame_of[idx];
		end else begin
			fault_total = fault_total + 32'd1;
			// Cannot happen with as many frames as pages, kept for completeness.
			if (next_frame >= NUM_FRAMES) begin
				r.st = dpt_pkg::ST_FULL;
			end else begin
				r.frame = next_frame[dpt_pkg::FRAME_OW-1:0];
				page_mapped[idx] = 1'b1;
				page_frame_of[idx] = next_frame[dpt_pkg::FRAME_OW-1:0];
				next_frame = next_frame + 11'd1;
				r.st = dpt_pkg::ST_LOADED;
			end
		end
		if (r.st == dpt_pkg::ST_HIT || r.st == dpt_pkg::ST_LOADED) begin
			fr = 64'(r.frame);
			r.paddr = dpt_pkg::PA_W'(fr * 64'(cur_page_size) + off);
		end
		r.xlat_cnt = xlat_total;
		r.fault_cnt = fault_total;
		return r;
	endfunction

	// Mostly short gaps, a few long ones, and calm stretches with none.
	function automatic int pick_gap();
		int r;
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 97)
			return $urandom_range(5, 40);
		return $urandom_range(41, 150);
	endfunction

	task automatic add_size(logic [dpt_pkg::PS_W-1:0] v);
		request_t q;
		q.is_cfg = 1'b1;
		q.size_val = v;
		q.vaddr = '0;
		pending.push_back(q);
	endtask

	task automatic add_addr(logic [dpt_pkg::VA_IN_W-1:0] a);
		request_t q;
		q.is_cfg = 1'b0;
		q.size_val = '0;
		q.vaddr = a;
		pending.push_back(q);
	endtask

	task automatic note_failure(string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] %s", $time, msg);
	endtask

	// Driver: presents requests and page size writes from the pending queue.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic     start_next;
		logic     we_next;
		request_t req;
		if (!arst_n) begin
			start <= 1'b0;
			page_size_we <= 1'b0;
			gap_left = 0;
		end else begin
			start_next = start;
			we_next = 1'b0;
			if (page_size_we)
				cur_page_size = clamp_size(page_size);
			if (start && !busy) begin
				expected_xlat.push_back(translate_address(virtual_address));
				start_next = 1'b0;
				gap_left = pick_gap();
			end
			if (!start_next && !page_size_we) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() > 0) begin
					if (!pending[0].is_cfg) begin
						req = pending.pop_front();
						virtual_address <= req.vaddr;
						start_next = 1'b1;
					end else if (expected_xlat.size() == 0 && !busy) begin
						// The page size only changes once every request has drained.
						req = pending.pop_front();
						page_size <= req.size_val;
						we_next = 1'b1;
						gap_left = pick_gap();
					end
				end
			end
			start <= start_next;
			page_size_we <= we_next;
		end
	end

	// Monitor: checks each result against the oldest prediction.
	always @(posedge clk) begin : check_proc
		xlat_t want;
		if (arst_n && done) begin
			if (expected_xlat.size() == 0) begin
				note_failure($sformatf("result with no request outstanding: pa=%h st=%0d",
					physical_address, status));
			end else begin
				want = expected_xlat.pop_front();
				if (physical_address !== want.paddr || frame_number !== want.frame ||
					status !== want.st || translation_count !== want.xlat_cnt ||
					fault_count !== want.fault_cnt)
					note_failure($sformatf(
						"mismatch pa %h/%h frame %0d/%0d st %0d/%0d xlat %0d/%0d fault %0d/%0d",
						want.paddr, physical_address, want.frame, frame_number,
						want.st, status, want.xlat_cnt, translation_count,
						want.fault_cnt, fault_count));
			end
		end
	end

	always @(posedge clk) begin : watchdog_proc
		if ((start && !busy) || done || page_size_we)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT)
			timed_out <= 1'b1;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : main_proc
		int unsigned n_random;
		int unsigned sel, ps, vpn, off, kind, count;
		int unsigned hot [8];
		logic [dpt_pkg::PS_W-1:0] size_val;

		// Directed part, starting at the reset page size of 4096.
		add_addr(32'h0000_0000);
		add_addr(32'h0000_0000);
		add_addr(32'h0000_0FFF);
		add_addr(32'h0000_1000);
		add_addr(32'h003F_FFFF);
		add_addr(32'h0040_0000);
		add_addr(32'hFFFF_FFFF);
		add_addr(32'h8000_0000);
		// A zero page size is taken as one byte per page.
		add_size(17'd0);
		add_addr(32'd1023);
		add_addr(32'd1024);
		add_addr(32'd7);
		// Oversized values saturate at 64 KiB; mappings keep their frames.
		add_size(17'h1FFFF);
		add_addr(32'h03FF_FFFF);
		add_addr(32'h0400_0000);
		add_addr(32'h0000_FFFF);
		add_size(17'd65537);
		add_addr(32'h0002_0005);
		add_size(dpt_pkg::PAGE_SIZE_MAX);
		add_addr(32'h03FF_0000);
		add_size(dpt_pkg::PAGE_SIZE_MIN);
		add_addr(32'h0000_0000);
		add_size(17'd3);
		add_addr(32'd3071);
		add_addr(32'd3072);
		add_addr(32'd100);

		// Random phases, each with its own page size and a few hot pages.
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0, 1, 2, 3: size_val = dpt_pkg::PS_W'(1 << $urandom_range(0, 16));
				4, 5, 6:    size_val = dpt_pkg::PS_W'($urandom_range(1, 65536));
				7:          size_val = dpt_pkg::PS_W'($urandom_range(1, 64));
				8:          size_val = $urandom_range(0, 1) ? dpt_pkg::PS_W'(0)
					: dpt_pkg::PS_W'($urandom_range(65537, 131071));
				default:    size_val = dpt_pkg::PAGE_SIZE_MAX;
			endcase
			add_size(size_val);
			ps = 32'(clamp_size(size_val));
			for (int h = 0; h < 8; h++)
				hot[h] = $urandom_range(0, NUM_PAGES - 1);
			count = $urandom_range(20, 90);
			for (int k = 0; k < count && n_random < RANDOM_ITEMS; k++) begin
				kind = $urandom_range(0, 99);
				off = $urandom_range(0, ps - 1);
				if (kind < 55)
					vpn = hot[$urandom_range(0, 7)];
				else if (kind < 80)
					vpn = $urandom_range(0, NUM_PAGES - 1);
				else
					vpn = $urandom_range(NUM_PAGES - 2, NUM_PAGES);
				if (kind < 90)
					add_addr(dpt_pkg::VA_IN_W'(vpn * ps + off));
				else
					add_addr($urandom);
				n_random++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (!timed_out && (pending.size() != 0 || start || page_size_we ||
			expected_xlat.size() != 0))
			@(negedge clk);
		if (timed_out) begin
			$display("CHECKS FAILED");
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (mismatches == 0 && expected_xlat.size() == 0 && !timed_out)
				$display("ALL CHECKS PASSED");
			else
				$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
